// ----- rtl/core/orb_pkg.sv -----
// ----------------------------------------------------------------------------
// orb_pkg: shared types and constants of the overwriting ring buffer
// Command codes, field widths, default sizes and the records that pass
// between the front end and the result queue.
// ----------------------------------------------------------------------------
package orb_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int CNT_W   = 5;

	// capacity register value after reset (clamped to DEPTH in the front end)
	localparam int CAP_RESET = 16;

	// result queue between the front end and the output side
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

	// status of one transaction, known at the front end
	typedef struct packed {
		logic             is_read;
		logic             err;
		logic             ovw;
		logic [CNT_W-1:0] count;
		logic             full;
		logic             empty;
	} orb_meta_t;

	// one complete result as it waits in the queue
	typedef struct packed {
		logic [VALUE_W-1:0] data;
		logic               err;
		logic               ovw;
		logic [CNT_W-1:0]   count;
		logic               full;
		logic               empty;
	} orb_res_t;

endpackage

// ----- rtl/core/overwriting_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// overwriting_ring_buffer: ring FIFO that overwrites its oldest entry
//
// Input channel: push/full. A transaction carries cmd (push, pop, peek) and
// value; it is taken at a clock edge with push high and full low.
// Result channel: empty/pop. While empty is low the oldest result sits on
// read_data, empty_error, overwrote, entry_count, is_full and is_empty; it
// is taken at an edge with pop high.
// Configuration: cfg_valid/cfg_ready write the capacity in use (always
// ready); a write also empties the ring. Zero acts as one, values above
// DEPTH act as DEPTH.
// Timing: a transaction updates the pointers and reads the RAM at the edge
// that takes it; its result is written to the queue at the next edge and
// only then reaches the result ports. One transaction per cycle is
// sustained while full is low, set by the single RAM access per command.
// Stalls: results wait in a four-entry queue; full rises once four results
// are queued or in flight and the input side then holds.
// Reset: ring empty, capacity 16 (or DEPTH if smaller), no results queued.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer
	import orb_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	input  logic               push,
	output logic               full,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VALUE_W-1:0] value,
	output logic               empty,
	input  logic               pop,
	output logic [VALUE_W-1:0] read_data,
	output logic               empty_error,
	output logic               overwrote,
	output logic [CNT_W-1:0]   entry_count,
	output logic               is_full,
	output logic               is_empty
);

	localparam int SW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int PTR_W = $clog2(DEPTH);

	logic             acc;
	logic             meta_valid;
	orb_meta_t        meta;
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [SW-1:0]    ram_wdata, ram_rdata;
	orb_res_t         head;

	assign cfg_ready = 1'b1;
	assign acc       = push && !full;

	orb_front #(
		.DEPTH (DEPTH),
		.SW    (SW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.acc        (acc),
		.cmd        (cmd),
		.value      (value),
		.meta_valid (meta_valid),
		.meta       (meta),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr)
	);

	orb_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	orb_result_q #(
		.SW (SW)
	) u_result_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.meta_valid (meta_valid),
		.meta       (meta),
		.ram_rdata  (ram_rdata),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	assign read_data   = head.data;
	assign empty_error = head.err;
	assign overwrote   = head.ovw;
	assign entry_count = head.count;
	assign is_full     = head.full;
	assign is_empty    = head.empty;

endmodule

// ----- rtl/core/orb_ram.sv -----
// ----------------------------------------------------------------------------
// orb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module orb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/orb_front.sv -----
// ----------------------------------------------------------------------------
// orb_front: command decode and ring pointer control
// Accepts a transaction, updates read/write positions and fill count,
// issues the RAM access and produces the status of the transaction.
// ----------------------------------------------------------------------------
module orb_front
	import orb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int SW    = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_data,
	input  logic                     acc,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [VALUE_W-1:0]       value,
	output logic                     meta_valid,
	output orb_meta_t                meta,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [SW-1:0]            ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CW    = (PTR_W > CNT_W) ? PTR_W : CNT_W;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] CAP_MAX  = CNT_W'((DEPTH < CNT_MAX) ? DEPTH : CNT_MAX);
	localparam logic [CNT_W-1:0] CAP_INIT = CNT_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);

	logic [CNT_W-1:0] cap_q;
	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic [PTR_W-1:0] rd_ptr_n, wr_ptr_n;
	logic [CNT_W-1:0] cnt_n;
	logic [CNT_W-1:0] cap_wr;

	// advance a position, wrapping at the capacity in use
	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] cap);
		logic [CW-1:0] inc;
		inc = CW'(p) + CW'(1);
		return (inc >= CW'(cap)) ? '0 : PTR_W'(inc);
	endfunction

	always_comb begin
		if (cfg_data == '0) begin
			cap_wr = CNT_W'(1);
		end else if (cfg_data > CAP_MAX) begin
			cap_wr = CAP_MAX;
		end else begin
			cap_wr = cfg_data;
		end
	end

	always_comb begin
		rd_ptr_n     = rd_ptr_q;
		wr_ptr_n     = wr_ptr_q;
		cnt_n        = cnt_q;
		meta.is_read = 1'b0;
		meta.err     = 1'b0;
		meta.ovw     = 1'b0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		if (acc) begin
			case (cmd)
				CMD_PUSH: begin
					ram_we   = 1'b1;
					wr_ptr_n = next_pos(wr_ptr_q, cap_q);
					if (cnt_q == cap_q) begin
						// ring full: drop the oldest entry
						rd_ptr_n = next_pos(rd_ptr_q, cap_q);
						meta.ovw = 1'b1;
					end else begin
						cnt_n = cnt_q + CNT_W'(1);
					end
				end
				CMD_POP, CMD_PEEK: begin
					if (cnt_q == '0) begin
						meta.err = 1'b1;
					end else begin
						ram_re       = 1'b1;
						meta.is_read = 1'b1;
						if (cmd == CMD_POP) begin
							rd_ptr_n = next_pos(rd_ptr_q, cap_q);
							cnt_n    = cnt_q - CNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
		meta.count = cnt_n;
		meta.full  = (cnt_n == cap_q);
		meta.empty = (cnt_n == '0);
	end

	assign meta_valid = acc;
	assign ram_waddr  = wr_ptr_q;
	assign ram_raddr  = rd_ptr_q;
	assign ram_wdata  = value[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_INIT;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (cfg_we) begin
			// new capacity empties the ring
			cap_q    <= cap_wr;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_n;
			wr_ptr_q <= wr_ptr_n;
			cnt_q    <= cnt_n;
		end
	end

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q)
		else $error("fill count above capacity");

	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(rd_ptr_q) < CW'(cap_q)) && (CW'(wr_ptr_q) < CW'(cap_q)))
		else $error("ring position outside capacity");

	a_ovw_keeps_full: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !cfg_we && meta.ovw) |=> (cnt_q == cap_q) && (rd_ptr_q == wr_ptr_q))
		else $error("overwrite left ring inconsistent");

endmodule

// ----- rtl/core/orb_result_q.sv -----
// ----------------------------------------------------------------------------
// orb_result_q: read data alignment and result queue
// Pairs the registered RAM read data with the transaction status and holds
// finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module orb_result_q
	import orb_pkg::*;
#(
	parameter int SW = DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          meta_valid,
	input  orb_meta_t     meta,
	input  logic [SW-1:0] ram_rdata,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output orb_res_t      head
);

	logic             valid_s1;
	orb_meta_t        meta_s1;
	orb_res_t         res_s1;
	orb_res_t         entry_q [RQ_DEPTH];
	logic [RQ_AW-1:0] head_q, tail_q;
	logic [RQ_AW:0]   qcnt_q;
	logic [RQ_AW:0]   occ;
	logic             deq;

	always_comb begin
		res_s1.data  = meta_s1.is_read ? VALUE_W'(ram_rdata) : '0;
		res_s1.err   = meta_s1.err;
		res_s1.ovw   = meta_s1.ovw;
		res_s1.count = meta_s1.count;
		res_s1.full  = meta_s1.full;
		res_s1.empty = meta_s1.empty;
	end

	// room is counted for the transaction still in flight
	assign occ   = qcnt_q + (RQ_AW+1)'(valid_s1);
	assign full  = (occ >= (RQ_AW+1)'(RQ_DEPTH));
	assign empty = (qcnt_q == '0);
	assign deq   = pop && !empty;
	assign head  = entry_q[head_q];

	always_ff @(posedge clk) begin
		meta_s1 <= meta;
		if (valid_s1) begin
			entry_q[tail_q] <= res_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			qcnt_q   <= '0;
		end else begin
			valid_s1 <= meta_valid;
			if (valid_s1) begin
				tail_q <= tail_q + RQ_AW'(1);
			end
			if (deq) begin
				head_q <= head_q + RQ_AW'(1);
			end
			case ({valid_s1, deq})
				2'b10:   qcnt_q <= qcnt_q + (RQ_AW+1)'(1);
				2'b01:   qcnt_q <= qcnt_q - (RQ_AW+1)'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (qcnt_q < (RQ_AW+1)'(RQ_DEPTH)))
		else $error("result queue overflow");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(deq && !valid_s1) |=> (qcnt_q == $past(qcnt_q) - (RQ_AW+1)'(1)))
		else $error("pop did not remove a result");

	a_flight_to_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(meta_valid && qcnt_q == '0 && !valid_s1) |=> ##1 !empty)
		else $error("accepted transaction did not reach the queue");

endmodule

// ----- tb/tb_overwriting_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// tb_overwriting_ring_buffer: self-checking bench for the overwriting ring FIFO
// Push, pop, peek and no-op transactions go in through the push/full queue
// port. A predictor of the ring tracks contents, positions and count under
// every capacity setting, and each result popped from the result queue is
// compared field by field with the oldest prediction. Both sides idle at
// random, with a stretch at full rate and a pause that lets the results drain.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_buffer;
	import orb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 33;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;
	logic               push;
	logic               full;
	logic [CMD_W-1:0]   cmd;
	logic [VALUE_W-1:0] value;
	logic               empty;
	logic               pop = 1'b0;
	logic [VALUE_W-1:0] read_data;
	logic               empty_error;
	logic               overwrote;
	logic [CNT_W-1:0]   entry_count;
	logic               is_full;
	logic               is_empty;

	// predicted ring state
	logic [VALUE_W-1:0] ring_mem [DEPTH_DEF];
	int                 rd_ptr;
	int                 wr_ptr;
	int                 held;
	logic [CNT_W-1:0]   cap_reg;

	orb_res_t pending_results[$];
	int       mismatches = 0;
	int       stall_cycles = 0;
	bit       tx_idle_on;
	bit       rx_idle_on;

	overwriting_ring_buffer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.value       (value),
		.empty       (empty),
		.pop         (pop),
		.read_data   (read_data),
		.empty_error (empty_error),
		.overwrote   (overwrote),
		.entry_count (entry_count),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

	always #5 clk = ~clk;

	// apply one command to the predicted ring and return the result it gives
	function automatic orb_res_t ring_apply(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
		orb_res_t r;
		int       cap;
		r = '0;
		// zero acts as one, anything above the depth saturates
		cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
		if (c == CMD_PUSH) begin
			ring_mem[wr_ptr] = v;
			wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
			if (held == cap) begin
				rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
				r.ovw = 1'b1;
			end else begin
				held++;
			end
		end else if (c == CMD_POP || c == CMD_PEEK) begin
			if (held == 0) begin
				r.err = 1'b1;
			end else begin
				r.data = ring_mem[rd_ptr];
				if (c == CMD_POP) begin
					rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
					held--;
				end
			end
		end
		r.count = held[CNT_W-1:0];
		r.full  = (held == cap);
		r.empty = (held == 0);
		return r;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
			logic [VALUE_W-1:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch on %0s: got 'h%0h, expected 'h%0h (t=%0t)",
				what, got, want, $time);
	endtask

	// one transaction on the input side; entered and left at a falling edge
	task automatic send_op(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
		while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
			push = 1'b0;
			@(negedge clk);
		end
		push  = 1'b1;
		cmd   = c;
		value = v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_results.insert(pending_results.size(), ring_apply(c, v));
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic wait_drained();
		push = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// capacity writes only with nothing in flight
	task automatic write_capacity(logic [CNT_W-1:0] c);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap_reg = c;
		rd_ptr  = 0;
		wr_ptr  = 0;
		held    = 0;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// random traffic; no-ops are sent but do not count toward n_ops
	task automatic run_traffic(int n_ops, int push_pct);
		int done;
		int r;
		done = 0;
		while (done < n_ops) begin
			r = $urandom_range(99);
			if (r < 3) begin
				send_op(CMD_NOP, pick_value());
			end else begin
				if (r < 3 + push_pct)
					send_op(CMD_PUSH, pick_value());
				else if ($urandom_range(2) != 0)
					send_op(CMD_POP, pick_value());
				else
					send_op(CMD_PEEK, pick_value());
				done++;
			end
		end
	endtask

	task automatic test_empty_and_nop();
		send_op(CMD_POP, 32'h1234_5678);
		send_op(CMD_PEEK, '1);
		send_op(CMD_NOP, '1);
		send_op(CMD_PUSH, '0);
		send_op(CMD_PUSH, '1);
		send_op(CMD_PEEK, '0);
		send_op(CMD_POP, '0);
		send_op(CMD_POP, '0);
		send_op(CMD_POP, '0);
		send_op(CMD_PEEK, '0);
	endtask

	task automatic test_small_capacity();
		write_capacity(5'd1);
		send_op(CMD_PUSH, 32'hA5A5_A5A5);
		send_op(CMD_PUSH, 32'h5A5A_5A5A);
		send_op(CMD_PEEK, '0);
		send_op(CMD_POP, '0);
		// zero behaves like one
		write_capacity(5'd0);
		send_op(CMD_PUSH, 32'h0000_0001);
		send_op(CMD_PUSH, 32'h8000_0000);
		send_op(CMD_POP, '0);
	endtask

	task automatic test_capacity_write_clears();
		write_capacity(5'd31);
		send_op(CMD_PUSH, 32'hDEAD_0001);
		send_op(CMD_PUSH, 32'hDEAD_0002);
		// the write empties the ring, stored words stay but are unreachable
		write_capacity(5'd2);
		send_op(CMD_POP, '0);
		send_op(CMD_PUSH, 32'h0F0F_0F0F);
		send_op(CMD_PUSH, 32'hF0F0_F0F0);
		send_op(CMD_PUSH, 32'hFFFF_0000);
		send_op(CMD_POP, '0);
	endtask

	task automatic test_random_mix();
		logic [CNT_W-1:0] caps [8] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd2, 5'd17, 5'd15, 5'd3};
		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 8)
				write_capacity(caps[ph]);
			else
				write_capacity(CNT_W'($urandom_range(31)));
			// alternate fill-heavy and drain-heavy phases
			run_traffic(50, 70);
			run_traffic(50, 30);
		end
	endtask

	task automatic test_back_to_back();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_capacity(5'd8);
		run_traffic(40, 60);
		run_traffic(40, 35);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_pause_until_drained();
		write_capacity(5'd5);
		run_traffic(40, 65);
		wait_drained();
		run_traffic(40, 40);
	endtask

	always @(negedge clk)
		pop = !(rx_idle_on && $urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin : result_check
		orb_res_t want;
		if (pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", read_data, '0);
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.data)
					report_mismatch("read_data", read_data, want.data);
				if (empty_error !== want.err)
					report_mismatch("empty_error", VALUE_W'(empty_error),
						VALUE_W'(want.err));
				if (overwrote !== want.ovw)
					report_mismatch("overwrote", VALUE_W'(overwrote),
						VALUE_W'(want.ovw));
				if (entry_count !== want.count)
					report_mismatch("entry_count", VALUE_W'(entry_count),
						VALUE_W'(want.count));
				if (is_full !== want.full)
					report_mismatch("is_full", VALUE_W'(is_full),
						VALUE_W'(want.full));
				if (is_empty !== want.empty)
					report_mismatch("is_empty", VALUE_W'(is_empty),
						VALUE_W'(want.empty));
			end
		end
	end

	// cycles without any transaction on any port
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("** overwriting_ring_buffer: FAILED **");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		push         = 1'b0;
		cmd          = CMD_NOP;
		value        = '0;
		tx_idle_on   = 1'b1;
		rx_idle_on   = 1'b1;
		cap_reg      = 5'd16;
		rd_ptr       = 0;
		wr_ptr       = 0;
		held         = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_and_nop();
		test_small_capacity();
		test_capacity_write_clears();
		test_random_mix();
		test_back_to_back();
		test_pause_until_drained();

		wait_drained();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("** overwriting_ring_buffer: PASSED **");
		else
			$display("** overwriting_ring_buffer: FAILED **");
		$finish;
	end

endmodule
